[hdl/kmsce_pkg.sv]
// Package for the key matrix scan code encoder.
// Holds word types, mode codes, the fixed make/break/repeat code tables and defaults.
// No dependencies.
`timescale 1ns / 1ps

package kmsce_pkg;

    // Defaults for the top level parameters.
    localparam int ROWS_DEFAULT      = 8;
    localparam int COLUMNS_DEFAULT   = 11;
    localparam int TIME_BITS_DEFAULT = 32;

    // Reset value of the repeat interval register in milliseconds.
    localparam logic [15:0] INTERVAL_RESET = 16'd100;

    // Size of the fixed code tables.
    localparam int ROM_ROWS    = 8;
    localparam int ROM_COLUMNS = 11;

    // Number of keys that repeat, and the width of a stamp slot index.
    localparam int REPEAT_KEYS = 6;
    localparam int SLOT_W      = 3;

    // Input word modes.
    localparam logic [1:0] MODE_KEY_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_PASS_END   = 2'd1;
    localparam logic [1:0] MODE_SYS_RESET  = 2'd2;

    // Register addresses (word index on the configuration port).
    localparam logic ADDR_REPEAT_INTERVAL = 1'b0;

    typedef logic [6:0] code_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  row;
        logic [3:0]  column;
        logic        pressed;
        logic [31:0] now_ms;
    } key_word_t;

    typedef struct packed {
        logic [6:0] scan_code;
        logic       strobe_res;
    } code_word_t;

    // Result of a repeat table lookup: whether the key repeats and its stamp slot.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } repeat_info_t;

    localparam code_t MAKE_ROM [ROM_ROWS][ROM_COLUMNS] = '{
        '{7'h6F, 7'h3E, 7'h32, 7'h34, 7'h36, 7'h38, 7'h3A, 7'h3C, 7'h00, 7'h4B, 7'h00},
        '{7'h7C, 7'h31, 7'h33, 7'h35, 7'h37, 7'h00, 7'h39, 7'h3B, 7'h3D, 7'h48, 7'h4C},
        '{7'h6D, 7'h20, 7'h22, 7'h24, 7'h26, 7'h00, 7'h28, 7'h2A, 7'h2C, 7'h47, 7'h49},
        '{7'h6C, 7'h54, 7'h21, 7'h23, 7'h25, 7'h27, 7'h29, 7'h2B, 7'h2D, 7'h44, 7'h4E},
        '{7'h6E, 7'h57, 7'h11, 7'h13, 7'h15, 7'h17, 7'h19, 7'h1B, 7'h59, 7'h45, 7'h46},
        '{7'h7D, 7'h70, 7'h12, 7'h14, 7'h16, 7'h00, 7'h18, 7'h1A, 7'h56, 7'h41, 7'h43},
        '{7'h71, 7'h73, 7'h0E, 7'h03, 7'h05, 7'h06, 7'h07, 7'h09, 7'h0B, 7'h42, 7'h4D},
        '{7'h72, 7'h7E, 7'h01, 7'h02, 7'h04, 7'h0F, 7'h08, 7'h0A, 7'h68, 7'h40, 7'h4A}
    };

    localparam code_t BREAK_ROM [ROM_ROWS][ROM_COLUMNS] = '{
        '{7'h7F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h00, 7'h74, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h00, 7'h77, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h79, 7'h00, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h76, 7'h00, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7B, 7'h00, 7'h00},
        '{7'h00, 7'h5E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h78, 7'h00, 7'h00}
    };

    // Make code of a matrix position; positions off the table have none.
    function automatic code_t make_code(input logic [2:0] row, input logic [3:0] column);
        code_t code;
        code = '0;
        if ((32'(row) < ROM_ROWS) && (32'(column) < ROM_COLUMNS))
        begin
            code = MAKE_ROM[row][column];
        end
        return code;
    endfunction

    // Release code of a matrix position; zero means the key sends no release.
    function automatic code_t break_code(input logic [2:0] row, input logic [3:0] column);
        code_t code;
        code = '0;
        if ((32'(row) < ROM_ROWS) && (32'(column) < ROM_COLUMNS))
        begin
            code = BREAK_ROM[row][column];
        end
        return code;
    endfunction

    // Repeating keys each own one time stamp slot.
    function automatic repeat_info_t repeat_info(input logic [2:0] row,
                                                 input logic [3:0] column);
        repeat_info_t info;
        info = '{hit: 1'b0, slot: '0};
        unique case ({row, column})
            {3'd1, 4'd8}: info = '{hit: 1'b1, slot: SLOT_W'(0)};
            {3'd5, 4'd1}: info = '{hit: 1'b1, slot: SLOT_W'(1)};
            {3'd6, 4'd0}: info = '{hit: 1'b1, slot: SLOT_W'(2)};
            {3'd6, 4'd1}: info = '{hit: 1'b1, slot: SLOT_W'(3)};
            {3'd7, 4'd0}: info = '{hit: 1'b1, slot: SLOT_W'(4)};
            {3'd7, 4'd5}: info = '{hit: 1'b1, slot: SLOT_W'(5)};
            default:      info = '{hit: 1'b0, slot: '0};
        endcase
        return info;
    endfunction

endpackage

[hdl/key_matrix_scan_code_encoder_unit.sv]
// Top level of the key matrix scan code encoder with typematic repeat.
// Depends on kmsce_pkg for word types, mode codes and the code tables.
// Contains the input register, the key state, the stamp registers and the result register.
`timescale 1ns / 1ps

// The encoder takes one word per clock cycle on the key channel and gives at most one
// word per input on the code channel, held first in the input register and then in the
// result register. Throughput is one word per cycle; it drops only while a finished code
// waits under code_stall and the next word would make another one. A key sample is
// checked against the stored level of its matrix position;
// a fresh press sends the make code with strobe_res set, a release of a make/break key
// sends its release code, and a held repeating key is sent again once the time since its
// last send exceeds the repeat interval register. An end-of-pass word with no level
// change in the pass drives code 0 without strobe, and a system reset word clears the
// repeat timers and drives code 0. Samples outside the matrix are dropped. The repeat
// interval lives at byte address 0 of the APB port and should only be written while no
// words are in flight.
module key_matrix_scan_code_encoder_unit #(
    parameter int ROWS      = kmsce_pkg::ROWS_DEFAULT,
    parameter int COLUMNS   = kmsce_pkg::COLUMNS_DEFAULT,
    parameter int TIME_BITS = kmsce_pkg::TIME_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // Key sample channel.
    input  logic                  key_valid,
    output logic                  key_stall,
    input  kmsce_pkg::key_word_t  key_word,

    // Scan code channel.
    output logic                  code_valid,
    input  logic                  code_stall,
    output kmsce_pkg::code_word_t code_word,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int KEYS  = ROWS * COLUMNS;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    // Configuration register.
    logic [15:0] interval_reg;

    // Input stage.
    logic                 in_valid_reg;
    kmsce_pkg::key_word_t in_word_reg;

    // Result stage.
    logic                  out_valid_reg;
    kmsce_pkg::code_word_t out_word_reg;

    // Key state.
    logic [KEYS-1:0]      key_down_reg;
    logic [KEYS-1:0]      key_down_next;
    logic [TIME_BITS-1:0] stamp_reg  [kmsce_pkg::REPEAT_KEYS];
    logic [TIME_BITS-1:0] stamp_next [kmsce_pkg::REPEAT_KEYS];
    logic                 pass_changed_reg;
    logic                 pass_changed_next;

    // Decode of the word in the input register.
    logic                    in_range;
    logic [KEY_W-1:0]        key_index;
    kmsce_pkg::code_t        make;
    kmsce_pkg::code_t        brk;
    kmsce_pkg::repeat_info_t rep;
    logic [63:0]             now_wide;
    logic [TIME_BITS-1:0]    now_t;
    logic [TIME_BITS-1:0]    elapsed;
    logic                    was_down;

    logic                  emit;
    kmsce_pkg::code_word_t emit_word;
    logic                  stage_go;
    logic                  key_accept;
    logic                  cfg_write;

    // ------------------------------------------------------------------
    // Configuration port. Writes take effect at the access cycle.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == kmsce_pkg::ADDR_REPEAT_INTERVAL);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == kmsce_pkg::ADDR_REPEAT_INTERVAL)
        begin
            prdata = {16'b0, interval_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= kmsce_pkg::INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            interval_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register moves on when its word either makes no
    // result or the result register is free to take it.
    // ------------------------------------------------------------------
    assign stage_go   = in_valid_reg && (!emit || !out_valid_reg || !code_stall);
    assign key_stall  = in_valid_reg && !stage_go;
    assign key_accept = key_valid && !key_stall;

    assign code_valid = out_valid_reg;
    assign code_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (key_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (stage_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_accept)
        begin
            in_word_reg <= key_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!code_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && emit)
        begin
            out_word_reg <= emit_word;
        end
    end

    // ------------------------------------------------------------------
    // Decode. Table lookups are by matrix position; the key state is
    // indexed by the flat position row * COLUMNS + column.
    // ------------------------------------------------------------------
    assign in_range  = (32'(in_word_reg.row) < ROWS) && (32'(in_word_reg.column) < COLUMNS);
    assign key_index = KEY_W'(32'(in_word_reg.row) * COLUMNS + 32'(in_word_reg.column));
    assign make      = kmsce_pkg::make_code(in_word_reg.row, in_word_reg.column);
    assign brk       = kmsce_pkg::break_code(in_word_reg.row, in_word_reg.column);
    assign rep       = kmsce_pkg::repeat_info(in_word_reg.row, in_word_reg.column);

    // Time is taken modulo 2^TIME_BITS, so the subtraction wraps on its own.
    assign now_wide = {32'b0, in_word_reg.now_ms};
    assign now_t    = now_wide[TIME_BITS-1:0];
    assign elapsed  = now_t - stamp_reg[rep.slot];
    assign was_down = in_range ? key_down_reg[key_index] : 1'b0;

    always_comb
    begin
        emit              = 1'b0;
        emit_word         = '{scan_code: '0, strobe_res: 1'b0};
        key_down_next     = key_down_reg;
        stamp_next        = stamp_reg;
        pass_changed_next = pass_changed_reg;

        unique case (in_word_reg.mode)
            kmsce_pkg::MODE_SYS_RESET:
            begin
                for (int i = 0; i < kmsce_pkg::REPEAT_KEYS; i++)
                begin
                    stamp_next[i] = '0;
                end
                pass_changed_next = 1'b0;
                emit              = 1'b1;
            end
            kmsce_pkg::MODE_PASS_END:
            begin
                // A quiet pass drives code 0 on the bus without a strobe.
                pass_changed_next = 1'b0;
                emit              = !pass_changed_reg;
            end
            kmsce_pkg::MODE_KEY_SAMPLE:
            begin
                if (in_range)
                begin
                    if (in_word_reg.pressed != was_down)
                    begin
                        if (in_word_reg.pressed)
                        begin
                            if (make != '0)
                            begin
                                emit      = 1'b1;
                                emit_word = '{scan_code: make, strobe_res: 1'b1};
                                if (rep.hit)
                                begin
                                    stamp_next[rep.slot] = now_t;
                                end
                            end
                        end
                        else if (brk != '0)
                        begin
                            emit      = 1'b1;
                            emit_word = '{scan_code: brk, strobe_res: 1'b1};
                        end
                        key_down_next[key_index] = in_word_reg.pressed;
                        pass_changed_next        = 1'b1;
                    end
                    else if (in_word_reg.pressed && rep.hit
                             && (elapsed > TIME_BITS'(interval_reg)))
                    begin
                        // Typematic repeat of a held key.
                        if (make != '0)
                        begin
                            emit      = 1'b1;
                            emit_word = '{scan_code: make, strobe_res: 1'b1};
                        end
                        stamp_next[rep.slot] = now_t;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State update, once per word leaving the input register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg     <= '0;
            pass_changed_reg <= 1'b0;
            for (int i = 0; i < kmsce_pkg::REPEAT_KEYS; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (stage_go)
        begin
            key_down_reg     <= key_down_next;
            pass_changed_reg <= pass_changed_next;
            stamp_reg        <= stamp_next;
        end
    end

endmodule
